[hw/rtl/state_variable_lowpass_filter_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the state variable lowpass filter core
// Short forms for clocked assertions that share clock and reset.
// ----------------------------------------------------------------------------
`ifndef STATE_VARIABLE_LOWPASS_FILTER_CORE_MACROS_SVH
`define STATE_VARIABLE_LOWPASS_FILTER_CORE_MACROS_SVH

// Check a consequence in the same cycle
`define SVF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the following cycle
`define SVF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/svf_pkg.sv]
// ----------------------------------------------------------------------------
// svf_pkg
// Types and constants shared by the state variable lowpass filter modules.
// ----------------------------------------------------------------------------
package svf_pkg;

   // Configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CUTOFF    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RESONANCE = 2'd1;

   // Coefficient formats: damping Q2.14, tuning Q2.15
   localparam int DAMP_BITS = 16;
   localparam int TUNE_BITS = 17;

   // 1.0 in Q1.15, and the tuning polynomial constants
   localparam logic [15:0] COEF_ONE = 16'd32768;
   localparam logic [16:0] K_185    = 17'd60621;
   localparam logic [14:0] K_085    = 15'd27853;

   // Rounding shift of the shared multiplier
   typedef enum logic {
      SH_Q15,
      SH_Q14
   } shift_type;

   typedef struct packed {
      logic      load;
      shift_type shift;
   } mul_ctl_type;

endpackage

[hw/rtl/svf_mul.sv]
// ----------------------------------------------------------------------------
// svf_mul
// Shared multiplier: signed operand times unsigned coefficient, scaled down
// by 2^14 or 2^15 with rounding half away from zero, result registered.
// ----------------------------------------------------------------------------
module svf_mul #(
   parameter int OP_BITS = 26
) (
   input  logic                                    clock,
   input  svf_pkg::mul_ctl_type                    mul_ctl,
   input  logic signed [OP_BITS-1:0]               operand,
   input  logic        [svf_pkg::TUNE_BITS-1:0]    coef,
   output logic signed [OP_BITS+3:0]               product
);
   import svf_pkg::*;

   localparam int FULL_BITS = OP_BITS + TUNE_BITS + 1;

   logic                      neg;
   logic [OP_BITS-1:0]        mag;
   logic [FULL_BITS-1:0]      full;
   logic [FULL_BITS-1:0]      biased;
   logic [OP_BITS+2:0]        rnd_mag;
   logic signed [OP_BITS+3:0] prod_in;
   logic signed [OP_BITS+3:0] prod_ff;

   // Multiply the magnitude, round half up, restore the sign
   always_comb begin
      neg  = operand[OP_BITS-1];
      mag  = neg ? (~$unsigned(operand)) + 1'b1 : $unsigned(operand);
      full = FULL_BITS'(mag) * FULL_BITS'(coef);
      case (mul_ctl.shift)
         SH_Q15: begin
            biased  = full + (FULL_BITS'(1) << 14);
            rnd_mag = (OP_BITS + 3)'(biased >> 15);
         end
         default: begin
            biased  = full + (FULL_BITS'(1) << 13);
            rnd_mag = (OP_BITS + 3)'(biased >> 14);
         end
      endcase
      prod_in = neg ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
   end

   // Hold the product until the next load
   always_ff @(posedge clock) begin
      if (mul_ctl.load) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

[hw/rtl/svf_coef.sv]
// ----------------------------------------------------------------------------
// svf_coef
// Configuration registers and coefficient sequencer: damping is
// min(resonance, 2 - frequency), tuning is f * (1.85 - 0.85 * f * damping).
// ----------------------------------------------------------------------------
module svf_coef (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [svf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [svf_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output logic                                 busy,
   output logic [svf_pkg::DAMP_BITS-1:0]        damping,
   output logic [svf_pkg::TUNE_BITS-1:0]        tuning
);
   import svf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAMP,
      ST_PROD,
      ST_SCALE,
      ST_TUNE
   } coef_state_type;

   coef_state_type         state_ff;
   logic [15:0]            freq_ff;
   logic [15:0]            reso_ff;
   logic [DAMP_BITS-1:0]   damp_ff;
   logic [TUNE_BITS-1:0]   tune_ff;
   logic [31:0]            prod_ff;
   logic [16:0]            scale_ff;

   logic [15:0]            clamp_in;
   logic [15:0]            limit;
   logic [DAMP_BITS-1:0]   damp_in;
   logic [31:0]            prod_in;
   logic [46:0]            scale_biased;
   logic [16:0]            scale_in;
   logic [15:0]            margin;
   logic [32:0]            tune_biased;
   logic [TUNE_BITS-1:0]   tune_in;

   // Clamp the write data, then one multiply per step
   always_comb begin
      clamp_in     = (csr_data > COEF_ONE) ? COEF_ONE : csr_data;
      limit        = 16'((17'h10000 - {1'b0, freq_ff}) >> 1);
      damp_in      = (reso_ff < limit) ? reso_ff : limit;
      prod_in      = 32'(freq_ff) * 32'(damp_ff);
      scale_biased = 47'(K_085) * 47'(prod_ff) + (47'd1 << 28);
      scale_in     = 17'(scale_biased >> 29);
      margin       = (K_185 > scale_ff) ? 16'(K_185 - scale_ff) : 16'd0;
      tune_biased  = 33'(freq_ff) * 33'(margin) + (33'd1 << 14);
      tune_in      = TUNE_BITS'(tune_biased >> 15);
   end

   // Sequencer and coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         freq_ff  <= '0;
         reso_ff  <= '0;
         damp_ff  <= '0;
         tune_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  case (csr_index)
                     CSR_CUTOFF: begin
                        freq_ff  <= clamp_in;
                        state_ff <= ST_DAMP;
                     end
                     CSR_RESONANCE: begin
                        reso_ff  <= clamp_in;
                        state_ff <= ST_DAMP;
                     end
                     default: begin
                        // drop writes to unknown registers
                     end
                  endcase
               end
            end
            ST_DAMP: begin
               damp_ff  <= damp_in;
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               prod_ff  <= prod_in;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               scale_ff <= scale_in;
               state_ff <= ST_TUNE;
            end
            ST_TUNE: begin
               tune_ff  <= tune_in;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign damping   = damp_ff;
   assign tuning    = tune_ff;

endmodule

[hw/rtl/state_variable_lowpass_filter_core.sv]
// ----------------------------------------------------------------------------
// state_variable_lowpass_filter_core
// Chamberlin state variable filter, lowpass output, on one shared multiplier.
// ----------------------------------------------------------------------------
// Each accepted sample runs ST_LP, ST_HP, ST_MUL, then ST_BP, which registers
// the result beat once the result register is free; the next sample is taken
// only back in ST_IDLE. The shared multiplier runs three products per sample
// (tuning x bandpass, damping x bandpass, tuning x highpass). A configuration
// write recomputes the coefficients; no sample is taken meanwhile. Reset clears
// both integrators, registers and coefficients, and drops any pending result.
`include "state_variable_lowpass_filter_core_macros.svh"

module state_variable_lowpass_filter_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int ACC_BITS    = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Sample in: tdata = audio_in
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // Result out: tdata = lowpass_out; tuser = clipped
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   output logic                                 rsp_tuser,
   // Register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [svf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [svf_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import svf_pkg::*;

   localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int WIDE_BITS = ((ACC_BITS > SAMPLE_BITS) ? ACC_BITS : SAMPLE_BITS) + 2;
   localparam int PROD_BITS = WIDE_BITS + 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LP,
      ST_HP,
      ST_MUL,
      ST_BP
   } core_state_type;

   core_state_type                  state_ff;
   logic signed [SAMPLE_BITS-1:0]   x_ff;
   logic signed [ACC_BITS-1:0]      lp_ff;
   logic signed [ACC_BITS-1:0]      bp_ff;
   logic signed [WIDE_BITS-1:0]     hp_ff;
   logic                            clip_ff;
   logic                            rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]          rsp_data_ff;
   logic                            rsp_clip_ff;

   logic                            coef_busy;
   logic [DAMP_BITS-1:0]            damping;
   logic [TUNE_BITS-1:0]            tuning;

   mul_ctl_type                     mul_ctl;
   logic signed [WIDE_BITS-1:0]     mul_operand;
   logic [TUNE_BITS-1:0]            mul_coef;
   logic signed [PROD_BITS-1:0]     product;

   logic                            req_fire;
   logic                            rsp_free;
   logic signed [PROD_BITS-1:0]     lp_sum;
   logic                            lp_ovf;
   logic signed [ACC_BITS-1:0]      lp_sat;
   logic signed [PROD_BITS-1:0]     hp_sum;
   logic signed [PROD_BITS-1:0]     bp_sum;
   logic                            bp_ovf;
   logic signed [ACC_BITS-1:0]      bp_sat;
   logic signed [WIDE_BITS-1:0]     y_ext;
   logic                            y_ovf;
   logic [SAMPLE_BITS-1:0]          y_sat;

   // Configuration registers and coefficients
   svf_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (coef_busy),
      .damping   (damping),
      .tuning    (tuning)
   );

   // Shared multiplier
   svf_mul #(
      .OP_BITS (WIDE_BITS)
   ) u_mul (
      .clock   (clock),
      .mul_ctl (mul_ctl),
      .operand (mul_operand),
      .coef    (mul_coef),
      .product (product)
   );

   assign req_tready = (state_ff == ST_IDLE) && !coef_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Steer the multiplier for each step
   always_comb begin
      mul_ctl.load  = 1'b0;
      mul_ctl.shift = SH_Q15;
      mul_operand   = WIDE_BITS'(bp_ff);
      mul_coef      = tuning;
      unique case (state_ff)
         ST_IDLE: begin
            mul_ctl.load = req_fire;
         end
         ST_LP: begin
            mul_ctl.load  = 1'b1;
            mul_ctl.shift = SH_Q14;
            mul_coef      = TUNE_BITS'(damping);
         end
         ST_MUL: begin
            mul_ctl.load = 1'b1;
            mul_operand  = hp_ff;
         end
         ST_HP, ST_BP: begin
            mul_ctl.load = 1'b0;
         end
         default: begin
            mul_ctl.load = 1'b0;
         end
      endcase
   end

   // Integrator updates with saturation, highpass, output clamp
   always_comb begin
      lp_sum = PROD_BITS'(lp_ff) + product;
      lp_ovf = lp_sum[PROD_BITS-1:ACC_BITS-1] != {(PROD_BITS-ACC_BITS+1){lp_sum[PROD_BITS-1]}};
      lp_sat = lp_ovf ? {lp_sum[PROD_BITS-1], {(ACC_BITS-1){~lp_sum[PROD_BITS-1]}}}
                      : lp_sum[ACC_BITS-1:0];

      hp_sum = PROD_BITS'(x_ff) - PROD_BITS'(lp_ff) - product;

      bp_sum = PROD_BITS'(bp_ff) + product;
      bp_ovf = bp_sum[PROD_BITS-1:ACC_BITS-1] != {(PROD_BITS-ACC_BITS+1){bp_sum[PROD_BITS-1]}};
      bp_sat = bp_ovf ? {bp_sum[PROD_BITS-1], {(ACC_BITS-1){~bp_sum[PROD_BITS-1]}}}
                      : bp_sum[ACC_BITS-1:0];

      y_ext = WIDE_BITS'(lp_ff);
      y_ovf = y_ext[WIDE_BITS-1:SAMPLE_BITS-1]
              != {(WIDE_BITS-SAMPLE_BITS+1){y_ext[WIDE_BITS-1]}};
      y_sat = y_ovf ? {y_ext[WIDE_BITS-1], {(SAMPLE_BITS-1){~y_ext[WIDE_BITS-1]}}}
                    : y_ext[SAMPLE_BITS-1:0];
   end

   // Sequencer, integrators and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lp_ff        <= '0;
         bp_ff        <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result beat once taken, unless the final step refills it
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_BP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  x_ff     <= req_tdata[SAMPLE_BITS-1:0];
                  state_ff <= ST_LP;
               end
            end
            ST_LP: begin
               lp_ff    <= lp_sat;
               clip_ff  <= lp_ovf;
               state_ff <= ST_HP;
            end
            ST_HP: begin
               hp_ff    <= hp_sum[WIDE_BITS-1:0];
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_BP;
            end
            ST_BP: begin
               // hold until the result register is free
               if (rsp_free) begin
                  bp_ff        <= bp_sat;
                  rsp_data_ff  <= y_sat;
                  rsp_clip_ff  <= clip_ff | bp_ovf | y_ovf;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(rsp_data_ff);
   assign rsp_tuser  = rsp_clip_ff;

   // Checks
   `SVF_ASSERT_NEXT(a_accept_starts, req_tvalid && req_tready, state_ff == ST_LP,
                    "accepted sample did not start the update")
   `SVF_ASSERT_NEXT(a_result_held, (state_ff == ST_BP) && rsp_tvalid && !rsp_tready,
                    (state_ff == ST_BP) && rsp_tvalid, "result lost while output stalled")
   `SVF_ASSERT_SAME(a_result_source, $rose(rsp_tvalid), $past(state_ff) == ST_BP,
                    "result beat raised outside the final step")

endmodule

[verif/tb_state_variable_lowpass_filter_core.sv]
// ----------------------------------------------------------------------------
// tb_state_variable_lowpass_filter_core
// Streams audio samples through the lowpass state variable filter core. A
// bit-exact software copy of the filter runs next to the core, and every
// result beat is checked against it. The run covers directed extremes, clamped
// and ignored register writes, unstable settings, random waveforms under
// several idle mixes, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_state_variable_lowpass_filter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import svf_pkg::*;

   localparam int SAMPLE_W    = 16;
   localparam int ACC_W       = 24;
   localparam int SEGMENTS    = 13;
   localparam int SEG_ITEMS   = 100;
   localparam int HOLD_CYCLES = 300;

   // Register indexes that the core ignores
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] lowpass;
      logic                clipped;
   } lowpass_beat_type;

   typedef enum int {
      WAVE_NOISE,
      WAVE_QUIET,
      WAVE_SQUARE,
      WAVE_SAW
   } wave_kind_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [SAMPLE_W-1:0]      req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]      rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index  = '0;
   logic [CSR_DATA_BITS-1:0] csr_data   = '0;

   logic [SAMPLE_W-1:0] sample_q[$];
   lowpass_beat_type    lowpass_expect_q[$];
   int                  send_idle_pct  = 0;
   int                  recv_stall_pct = 0;
   logic                pressure_go    = 1'b0;
   logic                rsp_hold       = 1'b0;
   int                  error_count    = 0;

   // Software copy of the filter registers, coefficients and integrators
   logic [15:0]             cutoff_reg     = '0;
   logic [15:0]             resonance_reg  = '0;
   logic [DAMP_BITS-1:0]    damp_q14       = '0;
   logic [TUNE_BITS-1:0]    tune_q15       = '0;
   logic signed [ACC_W-1:0] lowpass_state  = '0;
   logic signed [ACC_W-1:0] bandpass_state = '0;

   state_variable_lowpass_filter_core #(
      .SAMPLE_BITS(SAMPLE_W),
      .ACC_BITS   (ACC_W)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------------
   // Filter arithmetic
   // ---------------------------------------------------------------------------

   // Damping = min(resonance, 2 - frequency); tuning = f * (1.85 - 0.85 * f * d)
   function automatic void update_coefs();
      longint unsigned f, r, lim, d, t, m;
      f   = (cutoff_reg > COEF_ONE) ? COEF_ONE : cutoff_reg;
      r   = (resonance_reg > COEF_ONE) ? COEF_ONE : resonance_reg;
      lim = (64'd65536 - f) >> 1;
      d   = (r < lim) ? r : lim;
      t   = (K_085 * (f * d) + (64'd1 << 28)) >> 29;
      m   = (K_185 > t) ? K_185 - t : 64'd0;
      damp_q14 = d[DAMP_BITS-1:0];
      tune_q15 = TUNE_BITS'((f * m + (64'd1 << 14)) >> 15);
   endfunction

   // x * c / 2^sh, rounded half away from zero
   function automatic longint mul_round(longint x, longint unsigned c, int sh);
      longint unsigned mag, prod;
      mag  = (x < 0) ? -x : x;
      prod = (mag * c + (64'd1 << (sh - 1))) >> sh;
      return (x < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic longint clamp_bits(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Advance both integrators by one sample and return the result beat
   function automatic lowpass_beat_type advance_filter(logic [SAMPLE_W-1:0] sample);
      longint           x, bp, lp_raw, lp_new, hp, bp_raw, bp_new, y;
      lowpass_beat_type beat;
      x      = longint'($signed(sample));
      bp     = longint'(bandpass_state);
      lp_raw = longint'(lowpass_state) + mul_round(bp, tune_q15, 15);
      lp_new = clamp_bits(lp_raw, ACC_W);
      hp     = x - lp_new - mul_round(bp, damp_q14, 14);
      bp_raw = bp + mul_round(hp, tune_q15, 15);
      bp_new = clamp_bits(bp_raw, ACC_W);
      y      = clamp_bits(lp_new, SAMPLE_W);
      lowpass_state  = lp_new[ACC_W-1:0];
      bandpass_state = bp_new[ACC_W-1:0];
      beat.lowpass = y[SAMPLE_W-1:0];
      beat.clipped = (lp_raw != lp_new) || (bp_raw != bp_new) || (y != lp_new);
      return beat;
   endfunction

   // ---------------------------------------------------------------------------
   // Clock, reset and run limit
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Sample driver: predict on each accepted beat, then offer the next one
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            lowpass_expect_q.push_back(advance_filter(req_tdata));
         if (req_tvalid && !req_tready) begin
            // hold the pending beat
         end else if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= sample_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor: compare each beat with the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      lowpass_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (lowpass_expect_q.size() == 0) begin
               $error("unexpected result beat: lowpass_out %0d clipped %0b",
                      $signed(rsp_tdata), rsp_tuser);
               error_count++;
            end else begin
               want = lowpass_expect_q.pop_front();
               if (rsp_tdata !== want.lowpass) begin
                  $error("lowpass_out: expected %0d, got %0d",
                         $signed(want.lowpass), $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tuser !== want.clipped) begin
                  $error("clipped: expected %0b, got %0b", want.clipped, rsp_tuser);
                  error_count++;
               end
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Hold off the output for a long stretch so the core backs up its input
   initial begin : receiver_hold_off
      wait (pressure_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   // Write one register and mirror it into the software copy
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CUTOFF: begin
            cutoff_reg = value;
            update_coefs();
         end
         CSR_RESONANCE: begin
            resonance_reg = value;
            update_coefs();
         end
         default: ;
      endcase
   endtask

   // Wait until every sample is sent and every result has come back
   task automatic drain_results();
      while (sample_q.size() != 0 || req_tvalid || lowpass_expect_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_wave(input wave_kind_type kind, input int count);
      int          period, amp, step_sz, acc;
      logic [15:0] val;
      period  = $urandom_range(2, 48);
      amp     = $urandom_range(0, 32767);
      step_sz = $urandom_range(1, 4096);
      acc     = 0;
      for (int n = 0; n < count; n++) begin
         case (kind)
            WAVE_NOISE:  val = 16'($urandom);
            WAVE_QUIET:  val = 16'(int'($urandom_range(0, 2047)) - 1024);
            WAVE_SQUARE: val = ((n / period) % 2) ? 16'(-amp - 1) : 16'(amp);
            default: begin
               acc = acc + step_sz;
               if (acc > 32767) acc = acc - 65536;
               val = 16'(acc);
            end
         endcase
         // drop in an occasional stray sample
         if ($urandom_range(99) < 5) val = 16'($urandom);
         sample_q.push_back(val);
      end
   endtask

   // Mostly in-range settings, some corners, some values above the clamp
   task automatic pick_settings();
      int sel, f, r;
      sel = $urandom_range(99);
      if (sel < 70) begin
         f = $urandom_range(1) ? $urandom_range(0, 6000) : $urandom_range(0, 32768);
         r = $urandom_range(0, 32768);
      end else if (sel < 80) begin
         f = $urandom_range(1) * 32768;
         r = $urandom_range(1) * 32768;
      end else begin
         f = $urandom_range(0, 65535);
         r = $urandom_range(0, 65535);
      end
      write_reg(CSR_CUTOFF, 16'(f));
      write_reg(CSR_RESONANCE, 16'(r));
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, 16'($urandom));
   endtask

   initial begin : stimulus
      while (reset) @(posedge clock);

      // Reset coefficients are zero: output stays at zero
      sample_q.push_back(16'h7FFF);
      sample_q.push_back(16'h8000);
      sample_q.push_back(16'hFFFF);
      sample_q.push_back(16'h0001);
      drain_results();

      // Full cutoff, no damping: unstable, integrators saturate
      write_reg(CSR_CUTOFF, COEF_ONE);
      write_reg(CSR_RESONANCE, 16'd0);
      repeat (4) sample_q.push_back(16'h7FFF);
      repeat (4) sample_q.push_back(16'h8000);
      sample_q.push_back(16'h0000);
      sample_q.push_back(16'h0001);
      sample_q.push_back(16'hFFFF);
      drain_results();

      // Values above the clamp, damping limited by 2 - frequency, ignored indexes
      write_reg(CSR_CUTOFF, 16'hFFFF);
      write_reg(CSR_RESONANCE, 16'hFFFF);
      write_reg(CSR_SPARE_LO, 16'h0000);
      write_reg(CSR_SPARE_HI, 16'hFFFF);
      for (int n = 0; n < 6; n++)
         sample_q.push_back(n[0] ? 16'h8000 : 16'h7FFF);
      drain_results();

      // Random segments, cycling through the idle mixes
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_results();
         pick_settings();
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         if (seg == SEGMENTS - 1) begin
            // long output hold-off while the input keeps offering beats
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            pressure_go    = 1'b1;
            queue_wave(WAVE_SQUARE, 60);
         end else begin
            queue_wave(wave_kind_type'($urandom_range(0, 3)), SEG_ITEMS);
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
